// ===== rtl/smq_pkg.sv =====
// Shared types and constants of the soil moisture qualifier.
package smq_pkg;

	// Width of the millisecond timestamps and time marks.
	localparam int TIME_BITS = 32;
	// Width of the configuration write data and of the time registers.
	localparam int CFG_DATA_BITS = 16;
	// Width of the configuration register index.
	localparam int CFG_INDEX_BITS = 3;
	// Width of a percentage.
	localparam int PCT_BITS = 7;

	// Counts outside the calibration window that mark a loose probe.
	localparam int MARGIN = 5;
	// Percentage at or below which the error is raised.
	localparam int LOW_LIMIT = 15;
	// Percentage of a probe in water.
	localparam int FULL = 100;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_AIR_VALUE = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WATER_VALUE = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_TIME = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DISCONNECT_HOLD = 3'd3;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} smq_state_t;

endpackage

// ===== rtl/soil_moisture_qualifier_unit.sv =====
// Soil moisture qualifier: calibration, disconnect hold and stability detection.
//
// Usage: a request on the input channel carries one raw sample and its
// millisecond timestamp; it is taken at a clock edge with in_valid high and
// in_stall low. Each request gives exactly one result on the output channel,
// taken at an edge with out_valid high and out_stall low.
// Configuration registers are written over the cfg channel (valid/ready);
// index 0 air value, 1 water value, 2 stable time, 3 disconnect hold.
// Writes to other indexes are dropped.
// Steps: the sequencer qualifies the sample in the check state, runs the
// bit-serial restoring divider over its SAMPLE_BITS+7-bit dividend (one
// quotient bit per cycle), updates the stability state and then loads the
// output register. A sample out of window or inside the disconnect hold
// skips both the divider and the update; equal calibration skips only the
// divider. One request is in work at a time; the next can be taken in the
// cycle after the previous result is loaded into the output register.
// Reset clears the sequencer, the output valid flag and all tracking state,
// and loads the default configuration. When the receiver stalls, the result
// holds in the output register, and a later finished result waits in the
// sequencer until that register is free.
module soil_moisture_qualifier_unit #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [SAMPLE_BITS-1:0]             sample,
	input  logic [smq_pkg::TIME_BITS-1:0]      now,
	// Output channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [SAMPLE_BITS-1:0]             raw_value,
	output logic [smq_pkg::PCT_BITS-1:0]       percent,
	output logic                               error_flag,
	output logic                               disconnected_flag,
	output logic                               stable_flag,
	// Configuration channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [smq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [smq_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import smq_pkg::*;

	// Dividend is |sample - air| * 100, which needs seven more bits.
	localparam int NUM_BITS = SAMPLE_BITS + 7;
	localparam int CNT_BITS = $clog2(NUM_BITS);
	localparam logic [SAMPLE_BITS-1:0] AIR_RESET = SAMPLE_BITS'(640);
	localparam logic [SAMPLE_BITS-1:0] WATER_RESET = SAMPLE_BITS'(280);

	smq_state_t state_q, state_next;

	// Configuration registers.
	logic [SAMPLE_BITS-1:0]   air_q, water_q;
	logic [CFG_DATA_BITS-1:0] stable_time_q, hold_q;

	// Tracking state.
	logic                 disc_q, error_q, stab_q;
	logic [TIME_BITS-1:0] disc_mark_q, window_mark_q;
	logic [PCT_BITS-1:0]  ref_q;

	// Captured request and working registers.
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [PCT_BITS-1:0]    pct_q;
	logic [NUM_BITS-1:0]    quo_q;
	logic [SAMPLE_BITS-1:0] rem_q, den_q;
	logic                   neg_q;
	logic [CNT_BITS-1:0]    cnt_q;

	// Output register.
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] raw_q;
	logic [PCT_BITS-1:0]    percent_q;
	logic                   err_out_q, disc_out_q, stab_out_q;

	// Handshake and sequencing strobes.
	logic accept, cfg_write, out_free, load_out;

	// Window check: bounds are signed so a bound beyond the range never trips.
	logic signed [SAMPLE_BITS+1:0] s_ext, lo_bound, hi_bound;
	logic                          out_win, hold_done, go_on;

	always_comb begin
		s_ext = $signed({2'b00, sample_q});
		lo_bound = $signed({2'b00, water_q}) - (SAMPLE_BITS+2)'(MARGIN);
		hi_bound = $signed({2'b00, air_q}) + (SAMPLE_BITS+2)'(MARGIN);
		out_win = (s_ext < lo_bound) || (s_ext > hi_bound);
		hold_done = (now_q - disc_mark_q) > {{(TIME_BITS-CFG_DATA_BITS){1'b0}}, hold_q};
		go_on = !out_win && (!disc_q || hold_done);
	end

	// Operands of the mapping: signed differences turned into magnitudes.
	logic [SAMPLE_BITS:0]   diff, span;
	logic [SAMPLE_BITS-1:0] diff_mag, span_mag;
	logic [NUM_BITS-1:0]    diff_ext, dividend;
	logic                   span_zero;

	always_comb begin
		diff = {1'b0, sample_q} - {1'b0, air_q};
		span = {1'b0, water_q} - {1'b0, air_q};
		diff_mag = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
		span_mag = span[SAMPLE_BITS] ? SAMPLE_BITS'(-span) : span[SAMPLE_BITS-1:0];
		span_zero = (span == '0);
		// Times 100 as 64 + 32 + 4.
		diff_ext = NUM_BITS'(diff_mag);
		dividend = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
	end

	// One restoring division step: the dividend shifts out at the top while
	// quotient bits shift in at the bottom.
	logic [SAMPLE_BITS:0]   trial;
	logic                   fits;
	logic [SAMPLE_BITS-1:0] rem_next;

	always_comb begin
		trial = {rem_q, quo_q[NUM_BITS-1]};
		fits = trial >= {1'b0, den_q};
		rem_next = fits ? SAMPLE_BITS'(trial - {1'b0, den_q}) : trial[SAMPLE_BITS-1:0];
	end

	// Clamped percentage and the stability comparison.
	logic [PCT_BITS-1:0] pct_calc;
	logic                window_due, near_ref;

	always_comb begin
		if (neg_q) begin
			pct_calc = '0;
		end else if (quo_q >= NUM_BITS'(FULL)) begin
			pct_calc = PCT_BITS'(FULL);
		end else begin
			pct_calc = quo_q[PCT_BITS-1:0];
		end
		window_due = (now_q - window_mark_q) >=
			{{(TIME_BITS-CFG_DATA_BITS){1'b0}}, stable_time_q};
		near_ref = ({1'b0, pct_calc} + 8'd1 >= {1'b0, ref_q}) &&
			({1'b0, pct_calc} <= {1'b0, ref_q} + 8'd1);
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				if (!go_on) state_next = ST_DONE;
				else if (span_zero) state_next = ST_UPDATE;
				else state_next = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Handshake outputs and strobes.
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		in_stall = (state_q != ST_IDLE);
		cfg_ready = (state_q == ST_IDLE);
		accept = (state_q == ST_IDLE) && in_valid;
		cfg_write = cfg_valid && cfg_ready;
		load_out = (state_q == ST_DONE) && out_free;
	end

	// Sequencer register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_q <= AIR_RESET;
			water_q <= WATER_RESET;
			stable_time_q <= CFG_DATA_BITS'(1000);
			hold_q <= CFG_DATA_BITS'(5000);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_AIR_VALUE: air_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_WATER_VALUE: water_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_STABLE_TIME: stable_time_q <= cfg_data;
				REG_DISCONNECT_HOLD: hold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Tracking state: disconnect, error and stability.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_q <= 1'b0;
			error_q <= 1'b0;
			stab_q <= 1'b0;
			disc_mark_q <= '0;
			window_mark_q <= '0;
			ref_q <= '0;
		end else if (state_q == ST_CHECK) begin
			if (out_win) begin
				disc_q <= 1'b1;
				error_q <= 1'b1;
				disc_mark_q <= now_q;
			end else if (disc_q && hold_done) begin
				disc_q <= 1'b0;
			end
		end else if (state_q == ST_UPDATE) begin
			error_q <= (pct_calc <= PCT_BITS'(LOW_LIMIT));
			if (window_due) begin
				if (near_ref) begin
					stab_q <= 1'b1;
				end else begin
					ref_q <= pct_calc;
					stab_q <= 1'b0;
				end
				window_mark_q <= now_q;
			end
		end
	end

	// Request capture and the bit-serial divider.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			now_q <= now;
		end
		unique case (state_q)
			ST_CHECK: begin
				pct_q <= '0;
				rem_q <= '0;
				den_q <= span_mag;
				cnt_q <= CNT_BITS'(NUM_BITS - 1);
				if (span_zero) begin
					quo_q <= '0;
					neg_q <= 1'b0;
				end else begin
					quo_q <= dividend;
					neg_q <= diff[SAMPLE_BITS] ^ span[SAMPLE_BITS];
				end
			end
			ST_DIV: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[NUM_BITS-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_UPDATE: begin
				pct_q <= pct_calc;
			end
			default: begin
			end
		endcase
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: result fields.
	always_ff @(posedge clk) begin
		if (load_out) begin
			raw_q <= sample_q;
			percent_q <= pct_q;
			err_out_q <= error_q;
			disc_out_q <= disc_q;
			stab_out_q <= stab_q;
		end
	end

	assign out_valid = out_valid_q;
	assign raw_value = raw_q;
	assign percent = percent_q;
	assign error_flag = err_out_q;
	assign disconnected_flag = disc_out_q;
	assign stable_flag = stab_out_q;

	// An accepted request always moves on to the qualification step.
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CHECK))
		else $error("accepted request did not reach the check step");

	// The divider leaves after its last step and goes to the update.
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (cnt_q == '0) |=> (state_q == ST_UPDATE))
		else $error("divider did not finish after its last step");

	// A disconnected result carries a zero percentage and the error.
	a_disc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && disc_out_q |-> (percent_q == '0) && err_out_q)
		else $error("disconnected result with nonzero percent or no error");

endmodule
